@@ sv/udv_pkg.sv @@
// Shared types and widths for the unit direction vector block.
// No dependencies; used by every module of the block.
package udv_pkg;

    localparam int COORD_W = 24;               // Q12.12 coordinate width
    localparam int MAG_W   = COORD_W;          // |to - from| fits in COORD_W bits
    localparam int SQ_W    = 2 * MAG_W;        // one squared component
    localparam int L2_W    = SQ_W + 2;         // sum of three squares
    localparam int FRAC_SH = 62;               // 2^62 scale of the right-hand side
    localparam int Q_W     = 31;               // magnitude 0 .. 2^30
    localparam int A_W     = L2_W + 2 * Q_W + 2; // (2q)^2 * L2 and partial products
    localparam int UNIT_W  = 32;               // Q1.30 result component

    typedef struct packed {
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] from_z;
        logic signed [COORD_W-1:0] to_x;
        logic signed [COORD_W-1:0] to_y;
        logic signed [COORD_W-1:0] to_z;
    } points_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic                     degenerate;
    } result_t;

    // What the front end hands to the lanes and the merge stage.
    typedef struct packed {
        logic [2:0]                neg;
        logic                      degen;
        logic [2:0][SQ_W-1:0]      sq;
        logic [L2_W-1:0]           l2;
    } front_t;

endpackage

@@ sv/udv_front.sv @@
// Front end: differences, magnitudes, squares and squared length.
// Depends on udv_pkg. Three register stages, one transfer per cycle.
module udv_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  udv_pkg::points_t   points,
    output logic               out_valid,
    output udv_pkg::front_t    front
);

    localparam int CW = udv_pkg::COORD_W;
    localparam int MW = udv_pkg::MAG_W;
    localparam int SW = udv_pkg::SQ_W;
    localparam int LW = udv_pkg::L2_W;

    logic [2:0]          valid_reg;
    logic [2:0]          valid_next;

    logic [2:0][MW-1:0]  mag_reg;
    logic [2:0][MW-1:0]  mag_next;
    logic [2:0]          neg1_reg;
    logic [2:0]          neg1_next;

    logic [2:0][SW-1:0]  sq_reg;
    logic [2:0][SW-1:0]  sq_next;
    logic [2:0]          neg2_reg;
    logic                zero2_reg;
    logic                zero2_next;

    udv_pkg::front_t     front_reg;
    udv_pkg::front_t     front_next;

    logic signed [CW:0]  diff [3];
    logic signed [CW:0]  ndiff [3];

    always_comb
    begin
        diff[0] = $signed({points.to_x[CW-1], points.to_x})
                - $signed({points.from_x[CW-1], points.from_x});
        diff[1] = $signed({points.to_y[CW-1], points.to_y})
                - $signed({points.from_y[CW-1], points.from_y});
        diff[2] = $signed({points.to_z[CW-1], points.to_z})
                - $signed({points.from_z[CW-1], points.from_z});
        for (int i = 0; i < 3; i++)
        begin
            ndiff[i]     = -diff[i];
            neg1_next[i] = diff[i][CW];
            mag_next[i]  = diff[i][CW] ? ndiff[i][MW-1:0] : diff[i][MW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SW'(mag_reg[i]) * SW'(mag_reg[i]);
        end
        zero2_next = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
    end

    always_comb
    begin
        front_next.neg   = neg2_reg;
        front_next.degen = zero2_reg;
        front_next.sq    = sq_reg;
        front_next.l2    = LW'(sq_reg[0]) + LW'(sq_reg[1]) + LW'(sq_reg[2]);
    end

    assign valid_next = {valid_reg[1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg1_reg  <= neg1_next;
        sq_reg    <= sq_next;
        neg2_reg  <= neg1_reg;
        zero2_reg <= zero2_next;
        front_reg <= front_next;
    end

    assign out_valid = valid_reg[2];
    assign front     = front_reg;

endmodule

@@ sv/udv_lane.sv @@
// One component lane: finds round(|d| * 2^30 / L) one bit per stage.
// Depends on udv_pkg. Q_W register stages, shifts and adds only.
module udv_lane
(
    input  logic                         clk,
    input  logic [udv_pkg::SQ_W-1:0]     mag_sq,
    input  logic [udv_pkg::L2_W-1:0]     l2,
    output logic [udv_pkg::Q_W-1:0]      q
);

    localparam int QB = udv_pkg::Q_W;
    localparam int AW = udv_pkg::A_W;
    localparam int LW = udv_pkg::L2_W;
    localparam int SW = udv_pkg::SQ_W;
    localparam int FS = udv_pkg::FRAC_SH;

    // Per stage: a = u^2*L2, b = u*L2 with u = 2q, r = mag^2 * 2^62.
    logic [AW-1:0] a_reg  [QB];
    logic [AW-1:0] b_reg  [QB];
    logic [AW-1:0] r_reg  [QB];
    logic [LW-1:0] l2_reg [QB];
    logic [QB-1:0] q_reg  [QB];

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        localparam int J = QB - 1 - s;

        logic [AW-1:0] a_in;
        logic [AW-1:0] b_in;
        logic [AW-1:0] r_in;
        logic [LW-1:0] l2_in;
        logic [QB-1:0] q_in;
        logic [AW-1:0] l2_ext;
        logic [AW-1:0] a_try;
        logic [AW-1:0] b_try;
        logic [AW-1:0] t_try;

        if (s == 0)
        begin : g_first
            assign a_in  = '0;
            assign b_in  = '0;
            assign r_in  = AW'({mag_sq, {FS{1'b0}}});
            assign l2_in = l2;
            assign q_in  = '0;
        end
        else
        begin : g_rest
            assign a_in  = a_reg[s-1];
            assign b_in  = b_reg[s-1];
            assign r_in  = r_reg[s-1];
            assign l2_in = l2_reg[s-1];
            assign q_in  = q_reg[s-1];
        end

        // Try q + 2^J, i.e. u + 2^(J+1); test (u-1)^2 * L2 <= r.
        assign l2_ext = AW'(l2_in);
        assign a_try  = a_in + (b_in << (J + 2)) + (l2_ext << (2 * J + 2));
        assign b_try  = b_in + (l2_ext << (J + 1));
        assign t_try  = a_try - (b_try << 1) + l2_ext;

        always_ff @(posedge clk)
        begin
            r_reg[s]  <= r_in;
            l2_reg[s] <= l2_in;
            if (t_try <= r_in)
            begin
                a_reg[s] <= a_try;
                b_reg[s] <= b_try;
                q_reg[s] <= q_in | (QB'(1) << J);
            end
            else
            begin
                a_reg[s] <= a_in;
                b_reg[s] <= b_in;
                q_reg[s] <= q_in;
            end
        end
    end

    assign q = q_reg[QB-1];

endmodule

@@ sv/unit_direction_vector.sv @@
// Top level: front end, three component lanes and the sign/merge stage.
// Depends on udv_pkg, udv_front and udv_lane.
//
//  channel  | ports                | transfer
//  ---------+----------------------+---------------------------------
//  input    | start, busy, points  | start high while busy low
//  result   | done, result         | done high for one cycle
//
// One item per cycle sustained; busy stays low. The path holds three
// front-end stages, one lane stage per quotient bit (31 bits, 0 .. 2^30)
// and one merge register. Reset clears only the valid pipeline. The
// receiver cannot stall, so nothing holds the pipeline.
module unit_direction_vector
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  udv_pkg::points_t    points,
    output logic                done,
    output udv_pkg::result_t    result
);

    localparam int QB = udv_pkg::Q_W;
    localparam int UW = udv_pkg::UNIT_W;

    logic                  front_valid;
    udv_pkg::front_t       front;
    logic [2:0][QB-1:0]    q;

    logic [QB-1:0]         valid_reg;
    logic [QB-1:0]         valid_next;
    logic [2:0]            neg_reg   [QB];
    logic                  degen_reg [QB];

    logic                  done_reg;
    udv_pkg::result_t      result_reg;
    udv_pkg::result_t      result_next;

    logic [UW-1:0]         mag_ext [3];
    logic [UW-1:0]         unit    [3];

    assign busy = 1'b0;

    udv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .points    (points),
        .out_valid (front_valid),
        .front     (front)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        udv_lane u_lane
        (
            .clk    (clk),
            .mag_sq (front.sq[i]),
            .l2     (front.l2),
            .q      (q[i])
        );
    end

    // Carry valid, signs and the degenerate flag alongside the lanes.
    assign valid_next = {valid_reg[QB-2:0], front_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0]   <= front.neg;
        degen_reg[0] <= front.degen;
        for (int s = 1; s < QB; s++)
        begin
            neg_reg[s]   <= neg_reg[s-1];
            degen_reg[s] <= degen_reg[s-1];
        end
        result_reg <= result_next;
    end

    // Apply signs; force a zero vector when the points coincide.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_ext[i] = UW'(q[i]);
            if (degen_reg[QB-1])
            begin
                unit[i] = '0;
            end
            else if (neg_reg[QB-1][i])
            begin
                unit[i] = -mag_ext[i];
            end
            else
            begin
                unit[i] = mag_ext[i];
            end
        end
        result_next.unit_x     = unit[0];
        result_next.unit_y     = unit[1];
        result_next.unit_z     = unit[2];
        result_next.degenerate = degen_reg[QB-1];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
